// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, ignored while reset is high.
`define QM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, but also checked while reset is high.
`define QM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/qm_pkg.sv -----
// Shared types, codes and queue-selection helpers for the three-queue manager.
// No dependencies.
package qm_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_SERVE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef logic [1:0] qid_t;

  localparam qid_t Q0 = 2'd0;
  localparam qid_t Q1 = 2'd1;
  localparam qid_t Q2 = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_SRC_EMPTY = 2'd1;
  localparam logic [1:0] ST_DST_FULL  = 2'd2;

  // Selector 3 aliases queue 2.
  function automatic qid_t pick_queue(input logic [1:0] sel);
    pick_queue = (sel == Q0 || sel == Q1) ? sel : Q2;
  endfunction

  // A move never lands on its own source.
  function automatic qid_t move_target(input qid_t src, input logic [1:0] dst);
    qid_t t;
    case (src)
      Q0:      t = (dst == Q1) ? Q1 : Q2;
      Q1:      t = (dst == Q0) ? Q0 : Q2;
      default: t = (dst == Q0) ? Q0 : Q1;
    endcase
    move_target = t;
  endfunction

endpackage

// ----- rtl/qm_mem.sv -----
// Queue storage: one write port, one read port, registered read data.
// Uses qm_pkg only for the common import convention.
module qm_mem import qm_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(3 * DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [3 * DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled command keeps it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/qm_ctrl.sv -----
// Command sequencer: head pointers, fill counts, memory control, result register.
// Depends on qm_pkg; drives the ports of qm_mem.
module qm_ctrl import qm_pkg::*; #(
  parameter int DEPTH  = 64,
  localparam int PW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int AW    = $clog2(3 * DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  input  logic [7:0]       item,
  input  logic [1:0]       src_queue,
  input  logic [1:0]       dst_queue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_item,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] src_count,
  output logic [CNT_W-1:0] dst_count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [7:0]       mem_rdata
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t           state;
  cmd_t             cmd_r;
  logic [7:0]       item_r;
  qid_t             src_r;
  qid_t             dst_r;
  logic [PW-1:0]    head  [3];
  logic [CNT_W-1:0] count [3];

  qid_t             in_src;
  qid_t             in_dst;
  logic             accept;
  logic             fire;
  logic [CNT_W-1:0] cnt_s;
  logic [CNT_W-1:0] cnt_d;
  logic [PW-1:0]    head_s;
  logic [PW-1:0]    head_inc;
  logic             src_empty;
  logic             dst_full;
  logic             do_pop;
  logic             do_push;
  logic [1:0]       st;
  logic [CNT_W:0]   tail_sum;
  logic [PW-1:0]    tail_pos;

  function automatic logic [AW-1:0] mem_addr(input qid_t q, input logic [PW-1:0] pos);
    mem_addr = AW'(AW'(q) * AW'(DEPTH)) + AW'(pos);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_src   = pick_queue(src_queue);
  assign in_dst   = (cmd_t'(cmd) == CMD_MOVE) ? move_target(in_src, dst_queue)
                                              : pick_queue(dst_queue);

  // Head read goes out on the accept edge; data is ready in the execute cycle.
  assign mem_re    = accept;
  assign mem_raddr = mem_addr(in_src, head[in_src]);

  always_comb begin
    cnt_s     = count[src_r];
    cnt_d     = count[dst_r];
    head_s    = head[src_r];
    src_empty = (cnt_s == '0);
    dst_full  = (cnt_d == CNT_W'(DEPTH));
    case (cmd_r)
      CMD_ADD: begin
        st      = dst_full ? ST_DST_FULL : ST_DONE;
        do_pop  = 1'b0;
        do_push = !dst_full;
      end
      CMD_MOVE: begin
        st      = src_empty ? ST_SRC_EMPTY : (dst_full ? ST_DST_FULL : ST_DONE);
        do_pop  = !src_empty && !dst_full;
        do_push = !src_empty && !dst_full;
      end
      default: begin
        st      = src_empty ? ST_SRC_EMPTY : ST_DONE;
        do_pop  = !src_empty;
        do_push = 1'b0;
      end
    endcase
    head_inc = (head_s == PW'(DEPTH - 1)) ? '0 : head_s + 1'b1;
    tail_sum = (CNT_W + 1)'(head[dst_r]) + (CNT_W + 1)'(cnt_d);
    tail_pos = (tail_sum >= (CNT_W + 1)'(DEPTH)) ? PW'(tail_sum - (CNT_W + 1)'(DEPTH))
                                                 : PW'(tail_sum);
  end

  assign fire      = (state == S_EXEC) && (!out_valid || out_ready);
  assign mem_we    = fire && do_push;
  assign mem_waddr = mem_addr(dst_r, tail_pos);
  assign mem_wdata = (cmd_r == CMD_MOVE) ? mem_rdata : item_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state     <= S_IDLE;
            status    <= st;
            out_item  <= (st == ST_DONE && (cmd_r == CMD_MOVE || cmd_r == CMD_READ))
                         ? mem_rdata : 8'd0;
            src_count <= (cmd_r == CMD_ADD) ? '0 : (do_pop ? cnt_s - 1'b1 : cnt_s);
            dst_count <= (cmd_r == CMD_SERVE || cmd_r == CMD_READ) ? '0
                         : (do_push ? cnt_d + 1'b1 : cnt_d);
            if (do_pop) begin
              head[src_r]  <= head_inc;
              count[src_r] <= cnt_s - 1'b1;
            end
            if (do_push) begin
              count[dst_r] <= cnt_d + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // a new beat loads on fire; otherwise the held beat leaves on its handshake
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(cmd);
      item_r <= item;
      src_r  <= in_src;
      dst_r  <= in_dst;
    end
  end

endmodule

// ----- rtl/three_queue_manager_with_move.sv -----
// Three byte FIFOs of DEPTH entries each, sharing one queue memory. A command
// (add, move, serve, read) has an accept cycle, which reads the source head
// from the memory, whose read data is registered, and an execute cycle, which
// writes the target tail and updates head pointers and fill counts. One command
// is in flight at a time, so the next is taken only once the last has executed.
// Each command yields one result beat held in an output register; the next
// command is accepted while that beat waits, but it holds in its execute cycle
// until the register frees. No clearing pass is needed after reset.
module three_queue_manager_with_move import qm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    item,
  input  logic [1:0]                    src_queue,
  input  logic [1:0]                    dst_queue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_item,
  output logic [1:0]                    status,
  output logic [$clog2(DEPTH + 1)-1:0]  src_count,
  output logic [$clog2(DEPTH + 1)-1:0]  dst_count
);

  localparam int AW = $clog2(3 * DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  qm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .item      (item),
    .src_queue (src_queue),
    .dst_queue (dst_queue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .status    (status),
    .src_count (src_count),
    .dst_count (dst_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  qm_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/qm_checker.sv -----
// Port-level checks for three_queue_manager_with_move, bound to the top level.
// Depends on qm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qm_checker import qm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   cmd,
  input logic [7:0]                   item,
  input logic [1:0]                   src_queue,
  input logic [1:0]                   dst_queue,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   out_item,
  input logic [1:0]                   status,
  input logic [$clog2(DEPTH + 1)-1:0] src_count,
  input logic [$clog2(DEPTH + 1)-1:0] dst_count
);

  // A stalled result beat stays up and keeps its payload.
  `QM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(status), "result beat dropped or changed while stalled")

  // One command in flight: the input is closed in the cycle after an accepted beat.
  `QM_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "input reopened before command executed")

  // A failed command returns no item.
  `QM_ASSERT(a_fail_no_item, out_valid && status != ST_DONE |-> out_item == 8'd0, "failed command returned an item")

  // An empty-source result reports an empty source.
  `QM_ASSERT(a_empty_count, out_valid && status == ST_SRC_EMPTY |-> src_count == '0, "empty source with nonzero count")

endmodule

bind three_queue_manager_with_move qm_checker #(.DEPTH(DEPTH)) u_qm_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for three_queue_manager_with_move (DEPTH 64).
// Depends on qm_pkg and the RTL top; a class-based scoreboard predicts every result beat.
// Directed corner commands first, then random fill / drain / mixed segments with idling.
module testbench;
  import qm_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_ITEMS   = 92;
  localparam int N_SEGS      = 8;

  typedef struct packed {
    logic [7:0]    out_item;
    logic [1:0]    status;
    logic [CW-1:0] src_count;
    logic [CW-1:0] dst_count;
  } result_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} mix_t;

  class queue_scoreboard;
    logic [7:0] lanes [3][$];
    result_t    expected_q [$];
    int         errors;
    int         n_cmds [4];
    int         n_status [3];

    // Mirror the queues and record the result this command must produce.
    function void note_cmd(cmd_t c, logic [7:0] it, logic [1:0] s_sel, logic [1:0] d_sel);
      int s;
      int d;
      logic [7:0] v;
      result_t r;
      r = '0;
      r.status = ST_DONE;
      s = (s_sel == 2'd3) ? 2 : int'(s_sel);
      case (c)
        CMD_ADD: begin
          d = (d_sel == 2'd3) ? 2 : int'(d_sel);
          if (lanes[d].size() >= DEPTH) r.status = ST_DST_FULL;
          else lanes[d].push_back(it);
          r.dst_count = CW'(lanes[d].size());
        end
        CMD_MOVE: begin
          // a move onto its own source (or selector 3) is sent to another queue
          d = (d_sel != 2'd3 && int'(d_sel) != s) ? int'(d_sel) : ((s == 2) ? 1 : 2);
          if (lanes[s].size() == 0) r.status = ST_SRC_EMPTY;
          else if (lanes[d].size() >= DEPTH) r.status = ST_DST_FULL;
          else begin
            v = lanes[s].pop_front();
            lanes[d].push_back(v);
            r.out_item = v;
          end
          r.src_count = CW'(lanes[s].size());
          r.dst_count = CW'(lanes[d].size());
        end
        default: begin
          if (lanes[s].size() == 0) r.status = ST_SRC_EMPTY;
          else begin
            v = lanes[s].pop_front();
            if (c == CMD_READ) r.out_item = v;
          end
          r.src_count = CW'(lanes[s].size());
        end
      endcase
      n_cmds[int'(c)]++;
      n_status[int'(r.status)]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] oi, logic [1:0] st, logic [CW-1:0] sc,
                               logic [CW-1:0] dc);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: out_item %0d status %0d", oi, st);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (oi !== want.out_item) begin
        $error("out_item: expected %0d, got %0d", want.out_item, oi);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (sc !== want.src_count) begin
        $error("src_count: expected %0d, got %0d", want.src_count, sc);
        errors++;
      end
      if (dc !== want.dst_count) begin
        $error("dst_count: expected %0d, got %0d", want.dst_count, dc);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  cmd_t          cmd;
  logic [7:0]    item;
  logic [1:0]    src_queue;
  logic [1:0]    dst_queue;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [7:0]    out_item;
  logic [1:0]    status;
  logic [CW-1:0] src_count;
  logic [CW-1:0] dst_count;

  logic gaps_on   = 1'b1;
  logic stalls_on = 1'b1;
  int   stall_left = 0;
  int   cycle_count = 0;

  queue_scoreboard sb;

  three_queue_manager_with_move #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .item      (item),
    .src_queue (src_queue),
    .dst_queue (dst_queue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .status    (status),
    .src_count (src_count),
    .dst_count (dst_count)
  );

  always #10 clk = ~clk;

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_cmd(cmd, item, src_queue, dst_queue);
      if (out_valid && out_ready) sb.check_result(out_item, status, src_count, dst_count);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("FAIL three_queue_manager_with_move");
      $finish;
    end
  end

  // Holds the beat until accepted; called and returns at a rising edge.
  task automatic send_cmd(cmd_t c, logic [7:0] it, logic [1:0] s, logic [1:0] d);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    item      <= it;
    src_queue <= s;
    dst_queue <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_segment(mix_t kind, logic [1:0] focus, int n);
    int r;
    logic [1:0] s;
    logic [1:0] d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 9) < 6) ? focus : 2'($urandom_range(0, 3));
      d = ($urandom_range(0, 9) < 8) ? focus : 2'($urandom_range(0, 3));
      case (kind)
        SEG_FILL: begin
          // adds all land on the focus queue so it runs past full
          if (r < 80) send_cmd(CMD_ADD, 8'($urandom), 2'($urandom_range(0, 3)), focus);
          else if (r < 90) send_cmd(CMD_MOVE, 8'($urandom), 2'($urandom_range(0, 3)), d);
          else if (r < 95) send_cmd(CMD_READ, 8'($urandom), s, 2'($urandom_range(0, 3)));
          else send_cmd(CMD_SERVE, 8'($urandom), s, 2'($urandom_range(0, 3)));
        end
        SEG_DRAIN: begin
          if (r < 15) send_cmd(CMD_ADD, 8'($urandom), s, 2'($urandom_range(0, 3)));
          else if (r < 35) send_cmd(CMD_MOVE, 8'($urandom), s, 2'($urandom_range(0, 3)));
          else if (r < 70) send_cmd(CMD_READ, 8'($urandom), s, 2'($urandom_range(0, 3)));
          else send_cmd(CMD_SERVE, 8'($urandom), s, 2'($urandom_range(0, 3)));
        end
        default:
          send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)));
      endcase
    end
  endtask

  initial begin
    mix_t kind;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cmd       <= CMD_ADD;
    item      <= 8'h00;
    src_queue <= 2'd0;
    dst_queue <= 2'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty sources, selector 3 on both sides, then adds to every queue
    send_cmd(CMD_READ,  8'h00, 2'd0, 2'd0);
    send_cmd(CMD_SERVE, 8'hFF, 2'd1, 2'd3);
    send_cmd(CMD_MOVE,  8'h00, 2'd3, 2'd0);
    send_cmd(CMD_ADD,   8'h00, 2'd0, 2'd0);
    send_cmd(CMD_ADD,   8'hFF, 2'd3, 2'd1);
    send_cmd(CMD_ADD,   8'h55, 2'd0, 2'd2);
    send_cmd(CMD_ADD,   8'hAA, 2'd0, 2'd3);
    send_cmd(CMD_ADD,   8'h81, 2'd1, 2'd0);
    // moves onto their own source get redirected, then plain moves, reads and serves
    send_cmd(CMD_MOVE,  8'h00, 2'd0, 2'd0);
    send_cmd(CMD_MOVE,  8'h00, 2'd1, 2'd1);
    send_cmd(CMD_MOVE,  8'h00, 2'd2, 2'd2);
    send_cmd(CMD_MOVE,  8'h00, 2'd3, 2'd3);
    send_cmd(CMD_MOVE,  8'h00, 2'd2, 2'd0);
    send_cmd(CMD_MOVE,  8'h00, 2'd0, 2'd1);
    send_cmd(CMD_MOVE,  8'h00, 2'd1, 2'd0);
    send_cmd(CMD_MOVE,  8'h00, 2'd0, 2'd3);
    send_cmd(CMD_READ,  8'h00, 2'd3, 2'd0);
    send_cmd(CMD_SERVE, 8'h00, 2'd1, 2'd0);
    send_cmd(CMD_READ,  8'h00, 2'd0, 2'd0);
    send_cmd(CMD_READ,  8'h00, 2'd1, 2'd0);
    send_cmd(CMD_READ,  8'h00, 2'd2, 2'd0);
    send_cmd(CMD_READ,  8'h00, 2'd1, 2'd0);
    send_cmd(CMD_SERVE, 8'h00, 2'd2, 2'd0);
    wait_drained();

    // first segment fills one queue to overflow; later ones are random
    for (int seg = 0; seg < N_SEGS; seg++) begin
      kind = (seg == 0) ? SEG_FILL : mix_t'($urandom_range(0, 2));
      gaps_on   <= ($urandom_range(0, 3) != 0);
      stalls_on <= ($urandom_range(0, 3) != 0);
      run_segment(kind, 2'($urandom_range(0, 3)), SEG_ITEMS);
      if (seg == 0 || seg == N_SEGS / 2) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d commands: %0d add, %0d move, %0d serve, %0d read",
             sb.n_cmds[0] + sb.n_cmds[1] + sb.n_cmds[2] + sb.n_cmds[3],
             sb.n_cmds[0], sb.n_cmds[1], sb.n_cmds[2], sb.n_cmds[3]);
    $display("%0d completed, %0d refused on empty source, %0d refused on full target",
             sb.n_status[0], sb.n_status[1], sb.n_status[2]);
    if (sb.errors == 0) begin
      $display("PASS three_queue_manager_with_move");
    end else begin
      $display("FAIL three_queue_manager_with_move");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qm_pkg.sv
rtl/qm_mem.sv
rtl/qm_ctrl.sv
rtl/three_queue_manager_with_move.sv
rtl/qm_checker.sv
dv/testbench.sv
